/* sv/etldt_pkg.sv */
// ----------------------------------------------------------------------------
// Epoch to local date and time: shared package
// Field layout of a result, year start and month start tables.
// ----------------------------------------------------------------------------
package etldt_pkg;

  localparam int EpochBits = 32;
  localparam int ZoneBits = 9;
  localparam int OutBits = 48;
  localparam int DaysBits = 16;
  localparam logic [11:0] EpochYear = 12'd1970;

  // Packed from the most significant member down, so sec lands in bit 0.
  typedef struct packed {
    logic [2:0]  wday;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  min;
    logic [5:0]  sec;
  } fields_t;

  localparam int FieldBits = $bits(fields_t);

  // Day number of 1 January of year 1970 + n, Gregorian, for n up to 137.
  function automatic logic [DaysBits-1:0] year_start(input logic [7:0] n);
    logic [16:0] acc;
    acc = 17'(n) * 17'd365 + 17'(({1'b0, n} + 9'd1) >> 2);
    if (n >= 8'd131) begin
      acc = acc - 17'd1;
    end
    return acc[DaysBits-1:0];
  endfunction

  // First day of year of month index m (0 is January).
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && m >= 4'd2) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

/* sv/etldt_split.sv */
// ----------------------------------------------------------------------------
// Epoch to local date and time: calendar split
// Seven register stages that turn a second count into calendar fields.
// ----------------------------------------------------------------------------
module etldt_split (
  input  logic                                clk,
  input  logic [6:0]                          en,
  input  logic [etldt_pkg::EpochBits-1:0]     t,
  output etldt_pkg::fields_t                  f,
  output logic [etldt_pkg::DaysBits-1:0]      days
);

  localparam logic [31:0] RecipDay = 32'd3257812230;
  localparam logic [17:0] SecPerDay = 18'd86400;
  localparam logic [17:0] Recip60 = 18'd139811;
  localparam logic [18:0] RecipYear = 19'd367458;
  localparam logic [16:0] Recip7 = 17'd74899;

  logic [17:0] t1;
  logic [15:0] q1;
  logic [17:0] r2;
  logic [15:0] q2;
  logic [15:0] days3;
  logic [16:0] sod3;
  logic [16:0] sod4;
  logic [15:0] days4;
  logic [10:0] mt4;
  logic [7:0]  n4;
  logic [15:0] dw4;
  logic [13:0] q74;
  logic [5:0]  sec5;
  logic [4:0]  hr5;
  logic [2:0]  wrem5;
  logic [7:0]  n5;
  logic [10:0] mt5;
  logic [15:0] days5;
  logic [8:0]  doy6;
  logic        leap6;
  logic [5:0]  min6;
  logic [5:0]  sec6;
  logic [4:0]  hr6;
  logic [2:0]  wrem6;
  logic [7:0]  n6;
  logic [15:0] days6;

  logic [63:0] prod1;
  logic [33:0] prod2;
  logic        over3;
  logic [34:0] prod4a;
  logic [17:0] x4;
  logic [36:0] prod4b;
  logic [15:0] d4;
  logic [32:0] prod4c;
  logic [28:0] prod5;
  logic [3:0]  mon7;
  logic [8:0]  mst7;
  logic [8:0]  ms7;

  assign prod1 = 64'(t) * 64'(RecipDay);
  assign prod2 = 34'(q1) * 34'(SecPerDay);
  assign over3 = r2 >= SecPerDay;
  assign prod4a = 35'(sod3) * 35'(Recip60);
  assign x4 = {days3, 2'b10};
  assign prod4b = 37'(x4) * 37'(RecipYear);
  assign d4 = days3 + 16'd4;
  assign prod4c = 33'(d4) * 33'(Recip7);
  assign prod5 = 29'(mt4) * 29'(Recip60);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t1 <= t[17:0];
      q1 <= prod1[63:48];
    end
    if (en[1]) begin
      r2 <= t1 - prod2[17:0];
      q2 <= q1;
    end
    if (en[2]) begin
      days3 <= q2 + 16'(over3);
      sod3 <= over3 ? 17'(r2 - SecPerDay) : r2[16:0];
    end
    if (en[3]) begin
      sod4 <= sod3;
      days4 <= days3;
      mt4 <= prod4a[33:23];
      n4 <= prod4b[36:29];
      dw4 <= d4;
      q74 <= prod4c[32:19];
    end
    if (en[4]) begin
      sec5 <= 6'(sod4 - 17'(mt4) * 17'd60);
      hr5 <= prod5[27:23];
      wrem5 <= 3'(17'(dw4) - 17'(q74) * 17'd7);
      n5 <= n4 + 8'(days4 >= etldt_pkg::year_start(n4 + 8'd1));
      mt5 <= mt4;
      days5 <= days4;
    end
    if (en[5]) begin
      doy6 <= 9'(days5 - etldt_pkg::year_start(n5));
      leap6 <= (n5[1:0] == 2'd2) && (n5 != 8'd130);
      min6 <= 6'(mt5 - 11'(hr5) * 11'd60);
      sec6 <= sec5;
      hr6 <= hr5;
      wrem6 <= wrem5;
      n6 <= n5;
      days6 <= days5;
    end
    if (en[6]) begin
      f.sec <= sec6;
      f.min <= min6;
      f.hour <= hr6;
      f.day <= 5'(doy6 - mst7 + 9'd1);
      f.month <= mon7;
      f.year <= etldt_pkg::EpochYear + 12'(n6);
      f.wday <= (wrem6 == 3'd0) ? 3'd7 : wrem6;
      days <= days6;
    end
  end

  always_comb begin
    mon7 = 4'd1;
    mst7 = 9'd0;
    ms7 = 9'd0;
    for (int i = 1; i < 12; i++) begin
      ms7 = etldt_pkg::month_start(4'(i), leap6);
      if (doy6 >= ms7) begin
        mon7 = 4'(i + 1);
        mst7 = ms7;
      end
    end
  end

endmodule

/* sv/epoch_to_local_date_time.sv */
// ----------------------------------------------------------------------------
// Epoch to local date and time
// Converts a Unix second count to local calendar fields with EU summer time.
// ----------------------------------------------------------------------------
// The slave stream takes a 32-bit UTC second count in s_tdata. The master
// stream gives one result per transaction with second, minute, hour, day,
// month, year and ISO weekday packed into m_tdata.
// The zone offset (tenths of an hour, signed) and the summer time enable are
// written over the APB port at addresses 0 and 4; the user must write them
// only while the stream is idle; the block itself does not enforce this.
// A transaction can enter every cycle unless stalled. The ten register stages
// are offset add, a seven-stage calendar split run twice side by side
// (standard time and one hour ahead), and two stages for the summer time test
// and the final selection. Every stage stalls only while its successor is full
// and stalled, so the pipeline fills up behind a stalled receiver and then
// drops s_tready. Reset clears all valid flags and both registers; no
// transaction is pending after reset.
// ----------------------------------------------------------------------------
module epoch_to_local_date_time (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // epoch_seconds
  output logic        m_tvalid,
  input  logic        m_tready,
  // second_of_minute, minute_of_hour, hour_of_day, day_of_month,
  // month_of_year, calendar_year, weekday, zero fill
  output logic [47:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int Stages = 10;
  localparam logic RegZone = 1'b0;
  localparam logic RegDst = 1'b1;

  logic signed [etldt_pkg::ZoneBits-1:0] zone;
  logic                                  dst_enable;
  logic [Stages-1:0]                     v;
  logic [Stages:0]                       ld;
  logic signed [18:0]                    offs;
  logic [31:0]                           offs_ext;
  logic [31:0]                           loc0;
  logic [31:0]                           locd0;
  etldt_pkg::fields_t                    std_f;
  etldt_pkg::fields_t                    alt_f;
  logic [15:0]                           std_days;
  logic [15:0]                           alt_days;
  etldt_pkg::fields_t                    fs8;
  etldt_pkg::fields_t                    fa8;
  logic [15:0]                           x8;
  logic [13:0]                           q8;
  logic [12:0]                           now8;
  logic [15:0]                           x;
  logic [32:0]                           xp;
  logic [2:0]                            r9;
  logic [4:0]                            ls9;
  logic signed [14:0]                    edge10;
  logic signed [14:0]                    now10;
  logic                                  summer;
  logic                                  dsel;
  logic                                  wr;

  assign wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegDst) ? {31'd0, dst_enable} : 32'(zone);

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= '0;
      dst_enable <= 1'b0;
    end else if (wr) begin
      if (paddr[2] == RegZone) begin
        zone <= pwdata[etldt_pkg::ZoneBits-1:0];
      end else begin
        dst_enable <= pwdata[0];
      end
    end
  end

  always_comb begin
    ld[Stages] = m_tready;
    for (int k = Stages - 1; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign s_tready = ld[0];
  assign m_tvalid = v[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) begin
        v[0] <= s_tvalid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (ld[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign offs = 19'(zone) * 19'sd360;
  assign offs_ext = 32'(offs);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      loc0 <= s_tdata + offs_ext;
      locd0 <= s_tdata + offs_ext + 32'd3600;
    end
  end

  etldt_split u_std (
    .clk  (clk),
    .en   (ld[7:1]),
    .t    (loc0),
    .f    (std_f),
    .days (std_days)
  );

  etldt_split u_alt (
    .clk  (clk),
    .en   (ld[7:1]),
    .t    (locd0),
    .f    (alt_f),
    .days (alt_days)
  );

  assign x = std_days + 16'd35 - 16'(std_f.day);
  assign xp = 33'(x) * 33'd74899;

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      fs8 <= std_f;
      fa8 <= alt_f;
      x8 <= x;
      q8 <= xp[32:19];
      now8 <= 13'(10'(std_f.day) * 10'd24 + 10'(std_f.hour)) * 13'd10;
    end
  end

  assign r9 = 3'(17'(x8) - 17'(q8) * 17'd7);
  assign ls9 = 5'd31 - 5'(r9);
  assign edge10 = 15'sd10 + 15'(zone) + 15'(15'(ls9) * 15'd240);
  assign now10 = 15'({2'b00, now8});

  always_comb begin
    summer = 1'b0;
    if (fs8.month > 4'd3 && fs8.month < 4'd10) begin
      summer = 1'b1;
    end else if (fs8.month == 4'd3) begin
      summer = now10 >= edge10;
    end else if (fs8.month == 4'd10) begin
      summer = now10 < edge10;
    end
  end

  assign dsel = dst_enable && summer;

  always_ff @(posedge clk) begin
    if (ld[9]) begin
      m_tdata <= {7'd0, dsel ? fa8 : fs8};
    end
  end

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while the receiver is ready");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[5:0] < 6'd60 && m_tdata[11:6] < 6'd60 &&
                  m_tdata[16:12] < 5'd24))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[21:17] != 5'd0 && m_tdata[25:22] != 4'd0 &&
                  m_tdata[25:22] <= 4'd12 && m_tdata[40:38] != 3'd0))
    else $error("date field out of range");

  a_summer_months: assert property (@(posedge clk) disable iff (rst)
    (v[8] && dsel) |-> (fs8.month >= 4'd3 && fs8.month <= 4'd10))
    else $error("summer hour applied outside March to October");

  a_no_dst: assert property (@(posedge clk) disable iff (rst)
    (!dst_enable && v[8] && ld[9]) |=> (m_tdata[40:0] == 41'($past(fs8))))
    else $error("summer hour applied while disabled");

endmodule

/* bench/epoch_to_local_date_time_checker.sv */
// ----------------------------------------------------------------------------
// Epoch to local date and time: result checker
// Watches both streams and the register port, predicts each local date and
// time from the accepted epoch and compares it with the result stream.
// ----------------------------------------------------------------------------
module epoch_to_local_date_time_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending,
  output int          summer_hits
);

  localparam logic [2:0] AddrZone = 3'd0;
  localparam logic [2:0] AddrDst = 3'd4;

  logic [8:0]          zone_q;
  logic                dst_q;
  etldt_pkg::fields_t  expected_dates[$];

  function automatic bit has_feb29(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic etldt_pkg::fields_t split_seconds(input logic [31:0] t,
                                                       output int unsigned dayno);
    etldt_pkg::fields_t f;
    int unsigned v, days, rem, y, m, len;
    int unsigned mlen[12];
    mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    v = t;
    f.sec = 6'(v % 60);
    v = v / 60;
    f.min = 6'(v % 60);
    v = v / 60;
    f.hour = 5'(v % 24);
    days = v / 24;
    dayno = days;
    f.wday = ((days + 4) % 7 == 0) ? 3'd7 : 3'((days + 4) % 7);
    y = 1970;
    rem = days;
    forever begin
      len = has_feb29(y) ? 366 : 365;
      if (rem < len) break;
      rem -= len;
      y++;
    end
    for (m = 0; m < 11; m++) begin
      len = (m == 1) ? (has_feb29(y) ? 29 : 28) : mlen[m];
      if (rem < len) break;
      rem -= len;
    end
    f.day = 5'(rem + 1);
    f.month = 4'(m + 1);
    f.year = 12'(y);
    return f;
  endfunction

  function automatic bit summer_time(input etldt_pkg::fields_t f, input int unsigned dayno,
                                     input int tz);
    int unsigned last_sun;
    int now10, edge10;
    if (f.month < 3 || f.month > 10) return 0;
    if (f.month > 3 && f.month < 10) return 1;
    last_sun = 31 - ((dayno + (31 - f.day) + 4) % 7);
    now10 = 10 * (int'(f.hour) + 24 * int'(f.day));
    edge10 = 10 + tz + 240 * int'(last_sun);
    return (f.month == 3) ? (now10 >= edge10) : (now10 < edge10);
  endfunction

  function automatic etldt_pkg::fields_t local_date_time(input logic [31:0] epoch);
    int tz;
    logic [31:0] lt;
    int unsigned dayno;
    etldt_pkg::fields_t f;
    tz = int'($signed(zone_q));
    lt = epoch + 32'(tz * 360);
    f = split_seconds(lt, dayno);
    if (dst_q && summer_time(f, dayno, tz)) begin
      f = split_seconds(lt + 32'd3600, dayno);
      summer_hits++;
    end
    return f;
  endfunction

  always @(posedge clk) begin
    etldt_pkg::fields_t want, got;
    if (rst) begin
      zone_q <= '0;
      dst_q <= 1'b0;
      mismatches <= 0;
      summer_hits = 0;
      pending <= 0;
      expected_dates.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == AddrZone) zone_q <= pwdata[8:0];
        if (paddr == AddrDst) dst_q <= pwdata[0];
      end
      if (s_tvalid && s_tready) expected_dates.push_back(local_date_time(s_tdata));
      if (m_tvalid && m_tready) begin
        got = etldt_pkg::fields_t'(m_tdata[etldt_pkg::FieldBits-1:0]);
        if (expected_dates.size() == 0) begin
          if (mismatches < 10) $display("Unexpected result %h", m_tdata);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_dates.pop_front();
          if (got !== want || m_tdata[47:etldt_pkg::FieldBits] !== '0) begin
            if (mismatches < 10) begin
              $display("Mismatch: expected %0d-%0d-%0d %0d:%0d:%0d wd%0d,",
                       want.year, want.month, want.day, want.hour, want.min, want.sec,
                       want.wday);
              $display("          got %0d-%0d-%0d %0d:%0d:%0d wd%0d",
                       got.year, got.month, got.day, got.hour, got.min, got.sec,
                       got.wday);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= expected_dates.size();
    end
  end
endmodule

/* bench/epoch_to_local_date_time_tb.sv */
// ----------------------------------------------------------------------------
// Epoch to local date and time: testbench
// Drives epochs under several zone and summer time settings with random
// stalls on both streams; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module epoch_to_local_date_time_tb;
  localparam logic [2:0] AddrZone = 3'd0;
  localparam logic [2:0] AddrDst = 3'd4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches, pending, summer_hits, epochs_sent;
  bit          calm;

  epoch_to_local_date_time u_dut (.*);
  epoch_to_local_date_time_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) m_tready <= calm || $urandom_range(99) >= 21;

  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_epoch(input logic [31:0] epoch);
    while (!calm && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= epoch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    epochs_sent++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  // Epochs near the EU switch-over instants and year ends are the interesting ones.
  function automatic logic [31:0] random_epoch();
    int unsigned y, d, m;
    logic [31:0] day_start;
    case ($urandom_range(3))
      0: return $urandom();
      1: begin
        y = $urandom_range(136);
        day_start = 32'(y * 365 + (y + 1) / 4) * 32'd86400;
        return day_start + 32'($urandom_range(86400 * 3)) - 32'd86400;
      end
      default: begin
        y = $urandom_range(135);
        m = $urandom_range(1) ? 89 : 303;
        d = y * 365 + (y + 1) / 4 + m - $urandom_range(6);
        return 32'(d) * 32'd86400 + 32'($urandom_range(7200 * 4)) - 32'd7200 * 2;
      end
    endcase
  endfunction

  initial begin
    int zones[6];
    zones = '{0, -120, 140, 10, 255, -256};
    epochs_sent = 0;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (zones[z]) begin
      write_register(AddrZone, 32'(zones[z]));
      write_register(AddrDst, 32'(z % 3 != 1));
      if (z == 0) begin
        send_epoch(32'd0);
        send_epoch(32'hFFFFFFFF);
        send_epoch(32'h80000000);
        send_epoch(32'd951782400);
        send_epoch(32'd4107542400);
        send_epoch(32'd1711846799);
        send_epoch(32'd1711846800);
        send_epoch(32'd1729990799);
        send_epoch(32'd1729990800);
        for (int b = 0; b < 32; b++) send_epoch(32'd1 << b);
      end
      calm = (z == 2);
      repeat (230) send_epoch(random_epoch());
      calm = 1'b0;
      drain();
    end
    $display("Converted %0d epochs over six zone settings, %0d in summer time.",
             epochs_sent, summer_hits);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* sim.f */
sv/etldt_pkg.sv
sv/etldt_split.sv
sv/epoch_to_local_date_time.sv
bench/epoch_to_local_date_time_checker.sv
bench/epoch_to_local_date_time_tb.sv
